// ===== rtl/lj_pair_energy_force_core_assert.svh =====
// assertion macros shared by the core rtl
`ifndef LJ_PAIR_ENERGY_FORCE_CORE_ASSERT_SVH
`define LJ_PAIR_ENERGY_FORCE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LJ_AST_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LJ_AST_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ljpef_pkg.sv =====
// types and constants of the lennard-jones pair core
package ljpef_pkg;

  localparam int unsigned VAL_W = 63;
  localparam int unsigned R2_W  = 24;
  localparam int unsigned Q_W   = 49;

  typedef logic [VAL_W-1:0] val_t;

  localparam val_t CAP62   = 63'h4000_0000_0000_0000;
  localparam val_t K24_LIM = CAP62 / 24;

  typedef enum logic [2:0] {
    REG_OVERALL  = 3'd0,
    REG_ATTRACT  = 3'd1,
    REG_REPULSE  = 3'd2,
    REG_STRENGTH = 3'd3,
    REG_SHIFT    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic             want;
    logic             rep;
    logic             skip;
    logic             zr;
    logic             ovf;
  } ctx_t;

  typedef struct packed {
    ctx_t ctx;
    val_t ir2;
  } m1tag_t;

  typedef struct packed {
    ctx_t ctx;
    val_t ir2;
    val_t lj;
  } m3tag_t;

  typedef struct packed {
    ctx_t ctx;
    val_t amag;
    logic gneg;
  } m4tag_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [31:0] energy;
    val_t        k;
    logic        gneg;
  } m5tag_t;

  typedef struct packed {
    logic [31:0] fz;
    logic [31:0] fy;
    logic [31:0] fx;
    logic [31:0] energy;
    logic        sat;
  } res_t;

endpackage

// ===== rtl/ljpef_mul.sv =====
// three-stage 64x64 multiplier, floor shift and cap at 2^62
module ljpef_mul import ljpef_pkg::*; #(
  parameter int unsigned SH = 32,
  parameter int unsigned TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output val_t          p,
  output logic          ovf,
  output logic [TW-1:0] out_tag
);

  logic [63:0]   pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [63:0]   pp_ll_nxt, pp_lh_nxt, pp_hl_nxt, pp_hh_nxt;
  logic [127:0]  prod_r, prod_nxt;
  logic [127:0]  shifted;
  val_t          p_r, p_nxt;
  logic          ovf_r, ovf_nxt;
  logic          v1_r, v2_r, v3_r;
  logic [TW-1:0] tag1_r, tag2_r, tag3_r;

  assign pp_ll_nxt = a[31:0]  * b[31:0];
  assign pp_lh_nxt = a[31:0]  * b[63:32];
  assign pp_hl_nxt = a[63:32] * b[31:0];
  assign pp_hh_nxt = a[63:32] * b[63:32];

  assign prod_nxt = {pp_hh_r, 64'd0} + {32'd0, pp_lh_r, 32'd0}
                  + {32'd0, pp_hl_r, 32'd0} + {64'd0, pp_ll_r};

  always_comb begin
    shifted = prod_r >> SH;
    ovf_nxt = shifted > {65'd0, CAP62};
    p_nxt   = ovf_nxt ? CAP62 : shifted[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      pp_ll_r <= pp_ll_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_hh_r <= pp_hh_nxt;
      tag1_r  <= in_tag;
      prod_r  <= prod_nxt;
      tag2_r  <= tag1_r;
      p_r     <= p_nxt;
      ovf_r   <= ovf_nxt;
      tag3_r  <= tag2_r;
    end
  end

  assign out_valid = v3_r;
  assign p         = p_r;
  assign ovf       = ovf_r;
  assign out_tag   = tag3_r;

endmodule

// ===== rtl/ljpef_div.sv =====
// pipelined restoring divider for 2^48 / d, four quotient bits per stage
module ljpef_div import ljpef_pkg::*; #(
  parameter int unsigned TW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [R2_W-1:0] d,
  input  logic [TW-1:0]   in_tag,
  output logic            out_valid,
  output logic [Q_W-1:0]  q,
  output logic [TW-1:0]   out_tag
);

  localparam int unsigned BPS = 4;
  localparam int unsigned NST = (Q_W + BPS - 1) / BPS;
  localparam int unsigned QB  = NST * BPS;
  localparam logic [QB-1:0] NUMER = {{(QB-Q_W){1'b0}}, 1'b1, {(Q_W-1){1'b0}}};

  logic [R2_W-1:0] rem_r [NST];
  logic [R2_W-1:0] rem_in [NST];
  logic [R2_W-1:0] rem_nxt [NST];
  logic [QB-1:0]   q_r [NST];
  logic [QB-1:0]   q_in [NST];
  logic [QB-1:0]   q_nxt [NST];
  logic [R2_W-1:0] d_r [NST];
  logic [R2_W-1:0] d_in [NST];
  logic            v_r [NST];
  logic            v_in [NST];
  logic [TW-1:0]   tag_r [NST];
  logic [TW-1:0]   tag_in [NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    if (s == 0) begin : g_first
      assign rem_in[s] = '0;
      assign q_in[s]   = '0;
      assign d_in[s]   = d;
      assign v_in[s]   = in_valid;
      assign tag_in[s] = in_tag;
    end else begin : g_next
      assign rem_in[s] = rem_r[s-1];
      assign q_in[s]   = q_r[s-1];
      assign d_in[s]   = d_r[s-1];
      assign v_in[s]   = v_r[s-1];
      assign tag_in[s] = tag_r[s-1];
    end

    always_comb begin
      logic [R2_W:0]   t;
      logic [R2_W-1:0] rem;
      logic [QB-1:0]   qq;
      rem = rem_in[s];
      qq  = q_in[s];
      for (int j = 0; j < BPS; j++) begin
        t = {rem, NUMER[QB-1-(s*BPS+j)]};
        if (t >= {1'b0, d_in[s]}) begin
          rem = t[R2_W-1:0] - d_in[s];
          qq  = {qq[QB-2:0], 1'b1};
        end else begin
          rem = t[R2_W-1:0];
          qq  = {qq[QB-2:0], 1'b0};
        end
      end
      rem_nxt[s] = rem;
      q_nxt[s]   = qq;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in[s];
      end
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        d_r[s]   <= d_in[s];
        tag_r[s] <= tag_in[s];
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign q         = q_r[NST-1][Q_W-1:0];
  assign out_tag   = tag_r[NST-1];

endmodule

// ===== rtl/lj_pair_energy_force_core.sv =====
// lennard-jones pair energy and force core, top level
//
//  channel | dir | beat contents
//  in_     | in  | tdata: sep_x, sep_y, sep_z (q4.12); tuser: want_force
//  out_    | out | tdata: pair_energy, force_x/y/z (q16.16); tuser: saturated
//  cfg_    | in  | apb registers, 4-byte stride, always ready
//
// one beat in and one beat out per cycle while the output is not stalled
// the pipeline runs through the 13-stage divider and six 3-stage multipliers in series
// reset clears every valid bit and loads the register defaults
// the whole pipeline holds on a stall; one skid entry behind the output register
// lets the pipeline take one more beat while a result waits
`include "lj_pair_energy_force_core_assert.svh"
module lj_pair_energy_force_core import ljpef_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // sep_x, sep_y, sep_z
  input  logic [0:0]   in_tuser,   // want_force
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // pair_energy, force_x, force_y, force_z
  output logic [0:0]   out_tuser,  // saturated
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  // configuration registers
  logic [R2_W-1:0] ovc_r, atc_r, rpc_r, str_r;
  logic [31:0]     esh_r;
  logic            cfg_wr;
  reg_idx_t        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovc_r <= '0;
      atc_r <= '0;
      rpc_r <= 24'd81561;
      str_r <= '0;
      esh_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_OVERALL:  ovc_r <= cfg_pwdata[R2_W-1:0];
        REG_ATTRACT:  atc_r <= cfg_pwdata[R2_W-1:0];
        REG_REPULSE:  rpc_r <= cfg_pwdata[R2_W-1:0];
        REG_STRENGTH: str_r <= cfg_pwdata[R2_W-1:0];
        REG_SHIFT:    esh_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OVERALL:  cfg_prdata = {8'd0, ovc_r};
      REG_ATTRACT:  cfg_prdata = {8'd0, atc_r};
      REG_REPULSE:  cfg_prdata = {8'd0, rpc_r};
      REG_STRENGTH: cfg_prdata = {8'd0, str_r};
      REG_SHIFT:    cfg_prdata = esh_r;
      default:      cfg_prdata = '0;
    endcase
  end

  // pipeline control
  logic en;
  logic skid_v_r, skid_v_nxt, out_v_r, out_v_nxt;
  res_t skid_r, skid_nxt, out_r, out_nxt, fin;
  logic fin_v;

  assign en        = !skid_v_r;
  assign in_tready = en;

  // front stages: squares, distance, cutoff decisions
  logic [2:0][15:0] sep0_r;
  logic             want0_r, v0_r;
  ctx_t             ctx1_nxt, ctx1_r, ctx2_nxt, ctx2_r, ctx3_nxt, ctx3_r;
  logic [2:0][30:0] sq1_nxt, sq1_r;
  logic             v1_r, v2_r, v3_r;
  logic [31:0]      sum2;
  logic [R2_W-1:0]  r2_2_nxt, r2_2_r, r2_3_r;
  logic             out0;

  always_comb begin
    ctx1_nxt      = '0;
    ctx1_nxt.want = want0_r;
    for (int i = 0; i < 3; i++) begin
      ctx1_nxt.neg[i] = sep0_r[i][15];
      ctx1_nxt.mag[i] = sep0_r[i][15] ? (~sep0_r[i] + 16'd1) : sep0_r[i];
      sq1_nxt[i]      = {15'd0, ctx1_nxt.mag[i]} * {15'd0, ctx1_nxt.mag[i]};
    end
  end

  always_comb begin
    sum2         = {1'b0, sq1_r[0]} + {1'b0, sq1_r[1]} + {1'b0, sq1_r[2]};
    r2_2_nxt     = sum2[31:8];
    ctx2_nxt     = ctx1_r;
    ctx2_nxt.zr  = r2_2_nxt == '0;
    ctx2_nxt.ovf = ctx2_nxt.zr;
  end

  always_comb begin
    ctx3_nxt      = ctx2_r;
    out0          = (r2_2_r > ovc_r) || (r2_2_r >= atc_r);
    ctx3_nxt.rep  = r2_2_r < rpc_r;
    ctx3_nxt.skip = out0 || (!ctx3_nxt.rep && str_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      sep0_r  <= in_tdata;
      want0_r <= in_tuser[0];
      ctx1_r  <= ctx1_nxt;
      sq1_r   <= sq1_nxt;
      ctx2_r  <= ctx2_nxt;
      r2_2_r  <= r2_2_nxt;
      ctx3_r  <= ctx3_nxt;
      r2_3_r  <= r2_2_r;
    end
  end

  // reciprocal of r2
  logic           dv_v;
  logic [Q_W-1:0] dv_q;
  ctx_t           dv_ctx;

  ljpef_div #(.TW($bits(ctx_t))) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v3_r), .d(r2_3_r), .in_tag(ctx3_r),
    .out_valid(dv_v), .q(dv_q), .out_tag(dv_ctx)
  );

  // powers of 1/r2
  m1tag_t m1_in, m1_out, m2_in, m2_out;
  m3tag_t m3_in, m3_out;
  logic   m1_v, m2_v, m3_v, m1_ovf, m2_ovf, m3_ovf;
  val_t   m1_p, m2_p, m3_p;

  always_comb begin
    m1_in.ctx = dv_ctx;
    m1_in.ir2 = dv_ctx.zr ? CAP62 : {{(VAL_W-Q_W){1'b0}}, dv_q};
  end

  ljpef_mul #(.SH(34), .TW($bits(m1tag_t))) u_m1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(dv_v),
    .a({1'b0, m1_in.ir2}), .b({1'b0, m1_in.ir2}), .in_tag(m1_in),
    .out_valid(m1_v), .p(m1_p), .ovf(m1_ovf), .out_tag(m1_out)
  );

  always_comb begin
    m2_in         = m1_out;
    m2_in.ctx.ovf = m1_out.ctx.ovf | m1_ovf;
  end

  ljpef_mul #(.SH(32), .TW($bits(m1tag_t))) u_m2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m1_v),
    .a({1'b0, m1_p}), .b({1'b0, m1_out.ir2}), .in_tag(m2_in),
    .out_valid(m2_v), .p(m2_p), .ovf(m2_ovf), .out_tag(m2_out)
  );

  always_comb begin
    m3_in.ctx     = m2_out.ctx;
    m3_in.ctx.ovf = m2_out.ctx.ovf | m2_ovf;
    m3_in.ir2     = m2_out.ir2;
    m3_in.lj      = m2_p;
  end

  ljpef_mul #(.SH(30), .TW($bits(m3tag_t))) u_m3 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m2_v),
    .a({1'b0, m2_p}), .b({1'b0, m2_p}), .in_tag(m3_in),
    .out_valid(m3_v), .p(m3_p), .ovf(m3_ovf), .out_tag(m3_out)
  );

  // lj^2 - lj and 2 lj^2 - lj as sign and magnitude
  ctx_t        ctxq_nxt, ctxq_r;
  val_t        ir2q_r, amagq_nxt, amagq_r;
  logic        anegq_nxt, anegq_r, gnegq_nxt, gnegq_r, vq_r;
  logic [63:0] twice_lj2, gmagq_nxt, gmagq_r;

  always_comb begin
    ctxq_nxt     = m3_out.ctx;
    ctxq_nxt.ovf = m3_out.ctx.ovf | m3_ovf;
    anegq_nxt    = m3_p < m3_out.lj;
    amagq_nxt    = anegq_nxt ? (m3_out.lj - m3_p) : (m3_p - m3_out.lj);
    twice_lj2    = {m3_p, 1'b0};
    gnegq_nxt    = twice_lj2 < {1'b0, m3_out.lj};
    gmagq_nxt    = gnegq_nxt ? ({1'b0, m3_out.lj} - twice_lj2)
                             : (twice_lj2 - {1'b0, m3_out.lj});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else if (en) begin
      vq_r <= m3_v;
    end
    if (en) begin
      ctxq_r  <= ctxq_nxt;
      ir2q_r  <= m3_out.ir2;
      amagq_r <= amagq_nxt;
      anegq_r <= anegq_nxt;
      gmagq_r <= gmagq_nxt;
      gnegq_r <= gnegq_nxt;
    end
  end

  // scaled attraction energy and raw force scale
  m4tag_t m4_in, m4f_out;
  logic   m4e_v, m4f_v, m4e_ovf, m4f_ovf, m4e_aneg;
  val_t   m4e_p, m4f_p;

  always_comb begin
    m4_in.ctx  = ctxq_r;
    m4_in.amag = amagq_r;
    m4_in.gneg = gnegq_r;
  end

  ljpef_mul #(.SH(28), .TW(1)) u_m4e (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vq_r),
    .a({1'b0, amagq_r}), .b({40'd0, str_r}), .in_tag(anegq_r),
    .out_valid(m4e_v), .p(m4e_p), .ovf(m4e_ovf), .out_tag(m4e_aneg)
  );

  ljpef_mul #(.SH(32), .TW($bits(m4tag_t))) u_m4f (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vq_r),
    .a(gmagq_r), .b({1'b0, ir2q_r}), .in_tag(m4_in),
    .out_valid(m4f_v), .p(m4f_p), .ovf(m4f_ovf), .out_tag(m4f_out)
  );

  // energy sum and clip, force scale times 24
  ctx_t               ctxe_nxt;
  val_t               emag, ke_nxt;
  logic               eo, co, ko;
  logic signed [65:0] e_sgn, e_bias, e_val;
  logic [31:0]        energy_nxt;
  m5tag_t             m5_in, m5_out;
  logic               ve_r, m5_v, m5_ovf;
  val_t               m5_p;

  always_comb begin
    ctxe_nxt = m4f_out.ctx;
    if (m4f_out.ctx.rep) begin
      emag = {12'd0, m4f_out.amag[VAL_W-1:12]};
      eo   = 1'b0;
    end else begin
      emag = m4e_p;
      eo   = m4e_ovf;
    end
    e_sgn  = m4e_aneg ? -$signed({3'b000, emag}) : $signed({3'b000, emag});
    e_bias = m4f_out.ctx.rep ? (66'sd65536 - $signed({42'd0, str_r})) : 66'sd0;
    e_val  = e_sgn + e_bias - $signed({{34{esh_r[31]}}, esh_r});
    co     = 1'b1;
    if (e_val > 66'sd2147483647) begin
      energy_nxt = 32'h7fff_ffff;
    end else if (e_val < -66'sd2147483648) begin
      energy_nxt = 32'h8000_0000;
    end else begin
      energy_nxt = e_val[31:0];
      co         = 1'b0;
    end
    if (m4f_p > K24_LIM) begin
      ke_nxt = CAP62;
      ko     = 1'b1;
    end else begin
      ke_nxt = (m4f_p << 4) + (m4f_p << 3);
      ko     = 1'b0;
    end
    ctxe_nxt.ovf = m4f_out.ctx.ovf | eo | co | (m4f_out.ctx.want & (m4f_ovf | ko));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= m4f_v;
    end
    if (en) begin
      m5_in.ctx    <= ctxe_nxt;
      m5_in.energy <= energy_nxt;
      m5_in.k      <= ke_nxt;
      m5_in.gneg   <= m4f_out.gneg;
    end
  end

  ljpef_mul #(.SH(16), .TW($bits(m5tag_t))) u_m5 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(ve_r),
    .a({1'b0, m5_in.k}), .b({40'd0, str_r}), .in_tag(m5_in),
    .out_valid(m5_v), .p(m5_p), .ovf(m5_ovf), .out_tag(m5_out)
  );

  // per-component force
  ctx_t        ctx6_in, ctx6_out;
  val_t        k1;
  logic [2:0]  m6_v, m6_ovf;
  val_t        m6_p [3];
  logic [31:0] energy6;
  logic        gneg6;

  always_comb begin
    ctx6_in     = m5_out.ctx;
    ctx6_in.ovf = m5_out.ctx.ovf | (m5_out.ctx.want & !m5_out.ctx.rep & m5_ovf);
    k1          = m5_out.ctx.rep ? m5_out.k : m5_p;
  end

  ljpef_mul #(.SH(26), .TW($bits(ctx_t))) u_m6x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m5_v),
    .a({1'b0, k1}), .b({48'd0, m5_out.ctx.mag[0]}), .in_tag(ctx6_in),
    .out_valid(m6_v[0]), .p(m6_p[0]), .ovf(m6_ovf[0]), .out_tag(ctx6_out)
  );

  ljpef_mul #(.SH(26), .TW(32)) u_m6y (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m5_v),
    .a({1'b0, k1}), .b({48'd0, m5_out.ctx.mag[1]}), .in_tag(m5_out.energy),
    .out_valid(m6_v[1]), .p(m6_p[1]), .ovf(m6_ovf[1]), .out_tag(energy6)
  );

  ljpef_mul #(.SH(26), .TW(1)) u_m6z (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m5_v),
    .a({1'b0, k1}), .b({48'd0, m5_out.ctx.mag[2]}), .in_tag(m5_out.gneg),
    .out_valid(m6_v[2]), .p(m6_p[2]), .ovf(m6_ovf[2]), .out_tag(gneg6)
  );

  // sign, clip and masking of the finished beat
  logic [2:0][31:0] fclip;
  logic [2:0]       fcov;
  logic             fneg;
  logic             ovf_fin;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fneg    = gneg6 ^ ctx6_out.neg[i];
      fcov[i] = 1'b0;
      if (fneg) begin
        if (m6_p[i] > 63'h0000_0000_8000_0000) begin
          fclip[i] = 32'h8000_0000;
          fcov[i]  = 1'b1;
        end else begin
          fclip[i] = ~m6_p[i][31:0] + 32'd1;
        end
      end else begin
        if (m6_p[i] > 63'h0000_0000_7fff_ffff) begin
          fclip[i] = 32'h7fff_ffff;
          fcov[i]  = 1'b1;
        end else begin
          fclip[i] = m6_p[i][31:0];
        end
      end
    end
    ovf_fin = ctx6_out.ovf | (ctx6_out.want & ((|m6_ovf) | (|fcov)));
    fin_v   = m6_v[0];
    if (ctx6_out.skip) begin
      fin        = '0;
      fin.sat    = ctx6_out.zr;
    end else begin
      fin.energy = energy6;
      fin.fx     = ctx6_out.want ? fclip[0] : '0;
      fin.fy     = ctx6_out.want ? fclip[1] : '0;
      fin.fz     = ctx6_out.want ? fclip[2] : '0;
      fin.sat    = ovf_fin;
    end
  end

  // output register with one skid entry
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (skid_v_r && (!out_v_r || out_tready)) begin
      out_nxt    = skid_r;
      out_v_nxt  = 1'b1;
      skid_v_nxt = 1'b0;
    end else if (en && fin_v) begin
      if (!out_v_r || out_tready) begin
        out_nxt   = fin;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = fin;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = {out_r.fz, out_r.fy, out_r.fx, out_r.energy};
  assign out_tuser[0] = out_r.sat;

  `LJ_AST_IMP(a_skid_has_out, skid_v_r, out_v_r, "skid holds a beat with output empty")
  `LJ_AST_NXT(a_skid_holds, skid_v_r && !out_tready, skid_v_r, "skid beat lost on stall")
  `LJ_AST_IMP(a_m4_lockstep, 1'b1, m4e_v == m4f_v, "energy and force multipliers out of step")
  `LJ_AST_IMP(a_m6_lockstep, 1'b1, m6_v[0] == m6_v[1] && m6_v[0] == m6_v[2],
              "component multipliers out of step")

endmodule
